// File: rtl/crtl_pkg.sv
// ----------------------------------------------------------------------------
// crtl_pkg: shared definitions for the coalescing range table
// Holds the item layout widths, the operation codes and the default table depth.
// ----------------------------------------------------------------------------
package crtl_pkg;

	// Default number of table entries.
	localparam int MAX_ENTRIES_DEF = 64;

	// Field widths.
	localparam int ADDR_W    = 64;
	localparam int END_W     = ADDR_W + 1;
	localparam int ENTRIES_W = 7;

	// Stream layouts.
	localparam int IN_DATA_W  = 2 * ADDR_W;
	localparam int IN_USER_W  = 2;
	localparam int OUT_DATA_W = 16;

	// Operation codes carried in tuser.
	typedef enum logic [IN_USER_W-1:0] {
		OP_CLEAR = 2'd0,
		OP_ADD   = 2'd1,
		OP_QUERY = 2'd2
	} op_t;

endpackage

// File: rtl/coalescing_range_table_lookup.sv
// ----------------------------------------------------------------------------
// coalescing_range_table_lookup: ordered range table with containment query
// Stores address ranges in a RAM, merges adjacent adds, answers containment.
// ----------------------------------------------------------------------------
// Usage: items arrive on the s_ channel; tuser holds the operation (clear,
// add, query) and tdata holds base and length. Every item gives exactly one
// result item on the m_ channel with the contained and overflow flags and the
// entry count after the item.
// Each entry is kept in a single RAM as its start and its 65-bit end; the
// last entry's start and size are also held in registers, so an add never
// reads the RAM.
// A clear or an unused op goes straight to the result, an add widens or appends
// an entry (or is dropped), and a query is rejected early against the overall
// bounds or scans the stored entries. The query time is set by the RAM read
// port, which scans one stored entry per cycle.
// One item is processed at a time; s_tready is high while the block is idle,
// even while a finished result still waits in the output register.
// When the receiver stalls, the result stays in the output register and the
// next item's result waits in the block until the register is free.
// Reset empties the table and clears the overall bounds; the RAM needs no
// clearing pass, since only entries below the count are ever read.
// ----------------------------------------------------------------------------
module coalescing_range_table_lookup #(
	parameter int MAX_ENTRIES = crtl_pkg::MAX_ENTRIES_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	// s_tdata: base [63:0], length [127:64]
	input  logic [crtl_pkg::IN_DATA_W-1:0]   s_tdata,
	// s_tuser: op [1:0]
	input  logic [crtl_pkg::IN_USER_W-1:0]   s_tuser,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	// m_tdata: contained [0], overflow [1], entries [8:2], zero fill [15:9]
	output logic [crtl_pkg::OUT_DATA_W-1:0]  m_tdata,
	output logic                             m_tvalid,
	input  logic                             m_tready
);

	import crtl_pkg::*;

	localparam int AW    = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
	localparam int CW    = $clog2(MAX_ENTRIES + 1);
	localparam int RAM_W = ADDR_W + END_W;

	typedef enum logic [2:0] {
		S_IDLE,
		S_ADD,
		S_ADD_END,
		S_QEND,
		S_QCHK,
		S_SCAN,
		S_OUT
	} state_t;

	state_t              state_q;
	logic [CW-1:0]       count_q;
	logic [CW-1:0]       issue_q;
	logic [AW-1:0]       wr_idx_q;
	logic [ADDR_W-1:0]   base_q;
	logic [ADDR_W-1:0]   len_q;
	logic [END_W-1:0]    qend_q;
	logic [END_W-1:0]    hi_end_q;
	logic [ADDR_W-1:0]   lowest_q;
	logic [ADDR_W-1:0]   last_start_q;
	logic [ADDR_W-1:0]   last_size_q;
	logic                dv_s1;
	logic                last_s1;
	logic                res_contained_q;
	logic                res_overflow_q;
	logic                m_tvalid_q;
	logic                out_contained_q;
	logic                out_overflow_q;
	logic [ENTRIES_W-1:0] out_entries_q;

	logic [RAM_W-1:0]    ram_rdata;
	logic [RAM_W-1:0]    ram_wdata;
	logic                ram_we;
	logic                issuing;
	logic [ADDR_W-1:0]   rd_start;
	logic [END_W-1:0]    rd_end;
	logic [END_W-1:0]    end_c;
	logic [END_W-1:0]    sum_c;
	logic [END_W-1:0]    qend_c;
	logic [CW-1:0]       count_m1;
	logic                hit;
	logic                in_bounds;
	logic                merge;

	// Entry storage: end in the upper bits, start in the lower bits.
	crtl_ram #(
		.WIDTH(RAM_W),
		.DEPTH(MAX_ENTRIES)
	) u_entry_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(wr_idx_q),
		.wdata(ram_wdata),
		.re   (issuing),
		.raddr(issue_q[AW-1:0]),
		.rdata(ram_rdata)
	);

	// Datapath helpers: ends are one bit wider than addresses.
	assign end_c     = {1'b0, last_start_q} + {1'b0, last_size_q};
	assign sum_c     = {1'b0, last_size_q} + {1'b0, len_q};
	assign qend_c    = {1'b0, base_q} + {1'b0, len_q};
	assign count_m1  = count_q - CW'(1);
	assign rd_start  = ram_rdata[ADDR_W-1:0];
	assign rd_end    = ram_rdata[RAM_W-1:ADDR_W];
	assign hit       = (base_q >= rd_start) && (qend_q <= rd_end);
	assign in_bounds = (count_q != '0) && (base_q >= lowest_q) && (qend_q <= hi_end_q);
	assign merge     = (count_q != '0) && !hi_end_q[END_W-1] &&
	                   (hi_end_q[ADDR_W-1:0] == base_q);
	assign issuing   = (state_q == S_SCAN) && (issue_q < count_q);
	assign ram_we    = (state_q == S_ADD_END);
	assign ram_wdata = {end_c, last_start_q};

	// Ports.
	assign s_tready = (state_q == S_IDLE);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {{(OUT_DATA_W - ENTRIES_W - 2){1'b0}}, out_entries_q,
	                   out_overflow_q, out_contained_q};

	// Sequencer with table state and the output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			count_q    <= '0;
			issue_q    <= '0;
			hi_end_q   <= '0;
			lowest_q   <= '0;
			dv_s1      <= 1'b0;
			last_s1    <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			// The output register fills from the result state and empties when taken.
			if ((state_q == S_OUT) && (!m_tvalid_q || m_tready)) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (s_tvalid) begin
						base_q          <= s_tdata[ADDR_W-1:0];
						len_q           <= s_tdata[IN_DATA_W-1:ADDR_W];
						res_contained_q <= 1'b0;
						res_overflow_q  <= 1'b0;
						case (s_tuser)
							OP_CLEAR: begin
								count_q  <= '0;
								lowest_q <= '0;
								hi_end_q <= '0;
								state_q  <= S_OUT;
							end
							OP_ADD:   state_q <= S_ADD;
							OP_QUERY: state_q <= S_QEND;
							default:  state_q <= S_OUT;
						endcase
					end
				end
				// Widen the last entry, append a new one, or drop the add.
				S_ADD: begin
					if (merge) begin
						last_size_q <= sum_c[END_W-1] ? '1 : sum_c[ADDR_W-1:0];
						wr_idx_q    <= count_m1[AW-1:0];
						state_q     <= S_ADD_END;
					end else if (count_q < CW'(MAX_ENTRIES)) begin
						last_start_q <= base_q;
						last_size_q  <= len_q;
						wr_idx_q     <= count_q[AW-1:0];
						if (count_q == '0) begin
							lowest_q <= base_q;
						end
						count_q <= count_q + CW'(1);
						state_q <= S_ADD_END;
					end else begin
						res_overflow_q <= 1'b1;
						state_q        <= S_OUT;
					end
				end
				// Write the entry back with its end; the RAM write rides this state.
				S_ADD_END: begin
					hi_end_q <= end_c;
					state_q  <= S_OUT;
				end
				S_QEND: begin
					qend_q  <= qend_c;
					state_q <= S_QCHK;
				end
				// Early reject against the overall bounds.
				S_QCHK: begin
					issue_q <= '0;
					dv_s1   <= 1'b0;
					state_q <= in_bounds ? S_SCAN : S_OUT;
				end
				// One read issued per cycle; the compare sees the previous read.
				S_SCAN: begin
					if (issuing) begin
						issue_q <= issue_q + CW'(1);
						last_s1 <= (issue_q == count_m1);
					end
					if (dv_s1 && (hit || last_s1)) begin
						res_contained_q <= hit;
						dv_s1           <= 1'b0;
						state_q         <= S_OUT;
					end else begin
						dv_s1 <= issuing;
					end
				end
				// Hand the result to the output register once it is free.
				S_OUT: begin
					if (!m_tvalid_q || m_tready) begin
						out_contained_q <= res_contained_q;
						out_overflow_q  <= res_overflow_q;
						out_entries_q   <= ENTRIES_W'(count_q);
						state_q         <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// A write only touches an entry that the count covers.
	a_write_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> ({1'b0, wr_idx_q} < {1'b0, count_q}))
		else $error("entry write beyond the entry count");

	// The count never exceeds the table depth.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(MAX_ENTRIES))
		else $error("entry count beyond table depth");

	// A scan only runs on a non-empty table and never issues past the count.
	a_scan_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN) |-> ((count_q != '0) && (issue_q <= count_q)))
		else $error("scan out of range");

	// A new result only enters the output register from the result state.
	a_out_load: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid_q) |-> ($past(state_q) == S_OUT))
		else $error("result loaded outside the result state");

endmodule

// File: rtl/crtl_ram.sv
// ----------------------------------------------------------------------------
// crtl_ram: generic simple dual-port RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module crtl_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule
